// ----- src/pfvs_pkg.sv -----
// ----------------------------------------------------------------------------
// pfvs_pkg
// Shared constants, codes and types of the page frame victim selector.
// ----------------------------------------------------------------------------
package pfvs_pkg;

    // Table geometry
    localparam int FRAMES = 16;
    localparam int FIDX_W = 4;
    localparam int AGE_W  = 8;
    localparam int MODE_W = 2;
    localparam int OP_W   = 3;
    localparam int RAND_W = 16;

    // Stream word widths
    localparam int IN_W  = 24;
    localparam int OUT_W = 8;

    // Victim policy register codes
    typedef enum logic [MODE_W-1:0] {
        MODE_RANDOM   = 2'd0,
        MODE_LRU      = 2'd1,
        MODE_FIFO     = 2'd2,
        MODE_FIFO_ALT = 2'd3
    } t_mode;

    // Operation codes; the two top codes are ignored
    typedef enum logic [OP_W-1:0] {
        OP_MAP   = 3'd0,
        OP_READ  = 3'd1,
        OP_WRITE = 3'd2,
        OP_PROT  = 3'd3,
        OP_AGE   = 3'd4,
        OP_REQ   = 3'd5
    } t_op;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } t_state;

    // Broadcast command from the sequencer to every cell
    typedef struct packed {
        logic              upd;
        t_op               op;
        logic [FIDX_W-1:0] idx;
        logic              pv;
        logic              clr;
        logic [FIDX_W-1:0] clr_idx;
    } t_cmd;

    // Candidate record handed from cell to cell during a scan
    typedef struct packed {
        logic              free_found;
        logic [FIDX_W-1:0] free_idx;
        logic              coin_found;
        logic [FIDX_W-1:0] coin_idx;
        logic              any_found;
        logic [FIDX_W-1:0] first_idx;
        logic [FIDX_W-1:0] last_idx;
        logic [FIDX_W-1:0] lru_idx;
        logic [AGE_W-1:0]  lru_age;
        logic              aft_found;
        logic [FIDX_W-1:0] aft_idx;
    } t_cand;

endpackage

// ----- src/page_frame_victim_selector_top.sv -----
// Map, reference, protect and aging words update the frame registers on acceptance.
// A request word is registered into the scan launch, then passes one register
// per frame cell along the scan chain; the result register captures its end.
// Other words are taken one per cycle while no request is in progress; after a
// request the next word is taken only once the result has been taken.
// Reset: synchronous, active low; clears all frames, FIFO pointer, mode to LRU.
// ----------------------------------------------------------------------------
// page_frame_victim_selector_top
// Page frame table with free frame allocation and victim selection by
// random, aging LRU or FIFO policy, built as a chain of frame cells.
// ----------------------------------------------------------------------------
module page_frame_victim_selector_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // opcode[2:0], frame_index[6:3], protect_value[7], random_bits[23:8]
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [pfvs_pkg::IN_W-1:0]    s_axis_tdata,
    // victim_frame[3:0], was_mapped[4], needs_writeback[5], out_of_frames[6]
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [pfvs_pkg::OUT_W-1:0]   m_axis_tdata,
    // replace_mode
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pfvs_pkg::MODE_W-1:0]  i_cfg_data
);
    import pfvs_pkg::*;

    t_state              r_state, n_state;
    t_mode               r_mode;
    logic [FIDX_W-1:0]   r_ptr;
    logic [RAND_W-1:0]   r_coins;
    logic                r_start;
    logic [FIDX_W-1:0]   r_vic;
    logic                r_wm, r_wb, r_oof;

    t_op                 w_op;
    logic                w_acc;
    logic                w_fin;
    t_cmd                w_cmd;
    t_cand               w_cand [0:FRAMES];
    logic                w_vld  [0:FRAMES];
    logic [FRAMES-1:0]   w_mapped, w_dirty;
    t_cand               w_res;
    logic [FIDX_W-1:0]   w_vic;
    logic                w_free;
    logic                w_upd_ptr;

    assign w_op  = t_op'(s_axis_tdata[2:0]);
    assign w_acc = s_axis_tvalid && s_axis_tready;

    // Configuration: taken at any time, written only while idle by contract
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_mode <= MODE_LRU;
        else if (i_cfg_valid) r_mode <= t_mode'(i_cfg_data);
    end

    // Frame cell chain
    assign w_cand[0] = '0;
    assign w_vld[0]  = r_start;

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        pfvs_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (FIDX_W'(g)),
            .i_cmd    (w_cmd),
            .i_coin   ((g < RAND_W) ? r_coins[g % RAND_W] : 1'b0),
            .i_ptr    (r_ptr),
            .i_vld    (w_vld[g]),
            .i_cand   (w_cand[g]),
            .o_vld    (w_vld[g+1]),
            .o_cand   (w_cand[g+1]),
            .o_mapped (w_mapped[g]),
            .o_dirty  (w_dirty[g])
        );
    end

    // Victim decision from the record leaving the last cell
    assign w_res  = w_cand[FRAMES];
    assign w_fin  = (r_state == ST_SCAN) && w_vld[FRAMES];
    assign w_free = w_res.free_found;

    always_comb begin
        w_upd_ptr = 1'b0;
        if (w_free) begin
            w_vic = w_res.free_idx;
        end else begin
            case (r_mode)
                MODE_RANDOM: begin
                    w_vic = w_res.coin_found ? w_res.coin_idx : w_res.last_idx;
                end
                MODE_LRU: begin
                    w_vic     = w_res.lru_idx;
                    w_upd_ptr = w_res.any_found;
                end
                default: begin
                    w_vic     = w_res.aft_found ? w_res.aft_idx : w_res.first_idx;
                    w_upd_ptr = w_res.any_found;
                end
            endcase
        end
    end

    // Command broadcast: table updates on acceptance, frame clear at scan end
    always_comb begin
        w_cmd.upd     = w_acc;
        w_cmd.op      = w_op;
        w_cmd.idx     = s_axis_tdata[6:3];
        w_cmd.pv      = s_axis_tdata[7];
        w_cmd.clr     = w_fin && w_res.any_found;
        w_cmd.clr_idx = w_vic;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && w_op == OP_REQ) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_vld[FRAMES]) n_state = ST_OUT;
            end
            ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Scan launch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_start <= 1'b0;
        else          r_start <= w_acc && (w_op == OP_REQ);
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_op == OP_REQ) r_coins <= s_axis_tdata[23:8];
    end

    // FIFO pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                r_ptr <= '0;
        else if (w_fin && w_upd_ptr) r_ptr <= w_vic;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            if (w_res.any_found) begin
                r_vic <= w_vic;
                r_wm  <= !w_free && w_mapped[w_vic];
                r_wb  <= !w_free && w_mapped[w_vic] && w_dirty[w_vic];
                r_oof <= 1'b0;
            end else begin
                r_vic <= '0;
                r_wm  <= 1'b0;
                r_wb  <= 1'b0;
                r_oof <= 1'b1;
            end
        end
    end

    assign m_axis_tdata = {1'b0, r_oof, r_wb, r_wm, r_vic};

`ifndef SYNTHESIS
    // No-victim result carries nothing else
    a_oof_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[5:0] == 6'd0)
        else $error("out_of_frames result with nonzero fields");

    // Writeback only for an evicted mapped page
    a_wb_mapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[4])
        else $error("writeback without mapped victim");

    // Input is never taken while a result is pending
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // Scan token reaches the chain end only during a scan
    a_token_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[FRAMES] |-> r_state == ST_SCAN)
        else $error("scan token outside scan");

    // A request launches the scan on the next cycle
    a_req_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_op == OP_REQ |=> r_start && r_state == ST_SCAN)
        else $error("request did not start scan");
`endif

endmodule

// ----- src/pfvs_cell.sv -----
// ----------------------------------------------------------------------------
// pfvs_cell
// One page frame: status bits and age, plus one stage of the scan chain that
// folds this frame into the candidate record and passes it on.
// ----------------------------------------------------------------------------
module pfvs_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [pfvs_pkg::FIDX_W-1:0] i_idx,
    input  pfvs_pkg::t_cmd             i_cmd,
    input  logic                       i_coin,
    input  logic [pfvs_pkg::FIDX_W-1:0] i_ptr,
    input  logic                       i_vld,
    input  pfvs_pkg::t_cand            i_cand,
    output logic                       o_vld,
    output pfvs_pkg::t_cand            o_cand,
    output logic                       o_mapped,
    output logic                       o_dirty
);
    import pfvs_pkg::*;

    logic             r_mapped, r_prot, r_ref, r_dirty;
    logic [AGE_W-1:0] r_age;
    logic             r_vld;
    t_cand            r_cand;
    t_cand            n_cand;
    logic             w_hit;
    logic             w_unp;

    assign w_hit = (i_cmd.idx == i_idx);
    assign w_unp = !r_prot;

    // Frame state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapped <= 1'b0;
            r_prot   <= 1'b0;
            r_ref    <= 1'b0;
            r_dirty  <= 1'b0;
            r_age    <= '0;
        end else if (i_cmd.clr && i_cmd.clr_idx == i_idx) begin
            r_mapped <= 1'b0;
            r_prot   <= 1'b0;
            r_ref    <= 1'b0;
            r_dirty  <= 1'b0;
            r_age    <= '0;
        end else if (i_cmd.upd) begin
            case (i_cmd.op)
                OP_MAP: begin
                    if (w_hit) begin
                        r_mapped <= 1'b1;
                        r_ref    <= 1'b0;
                        r_dirty  <= 1'b0;
                        r_age    <= '0;
                    end
                end
                OP_READ: begin
                    if (w_hit && r_mapped) r_ref <= 1'b1;
                end
                OP_WRITE: begin
                    if (w_hit && r_mapped) begin
                        r_ref   <= 1'b1;
                        r_dirty <= 1'b1;
                    end
                end
                OP_PROT: begin
                    if (w_hit) r_prot <= i_cmd.pv;
                end
                OP_AGE: begin
                    if (r_mapped) begin
                        r_age <= {r_ref, r_age[AGE_W-1:1]};
                        r_ref <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Fold this frame into the passing candidate record
    always_comb begin
        n_cand = i_cand;
        if (w_unp && !r_mapped && !i_cand.free_found) begin
            n_cand.free_found = 1'b1;
            n_cand.free_idx   = i_idx;
        end
        if (w_unp && i_coin && !i_cand.coin_found) begin
            n_cand.coin_found = 1'b1;
            n_cand.coin_idx   = i_idx;
        end
        if (w_unp) begin
            n_cand.any_found = 1'b1;
            n_cand.last_idx  = i_idx;
            if (!i_cand.any_found) n_cand.first_idx = i_idx;
            // strict compare keeps ties on the lower frame
            if (!i_cand.any_found || r_age < i_cand.lru_age) begin
                n_cand.lru_idx = i_idx;
                n_cand.lru_age = r_age;
            end
        end
        if (w_unp && i_idx > i_ptr && !i_cand.aft_found) begin
            n_cand.aft_found = 1'b1;
            n_cand.aft_idx   = i_idx;
        end
    end

    // Chain stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else          r_vld <= i_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) r_cand <= n_cand;
    end

    assign o_vld    = r_vld;
    assign o_cand   = r_cand;
    assign o_mapped = r_mapped;
    assign o_dirty  = r_dirty;

endmodule
